// ===== hw/rtl/bfsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsl_pkg
// Shared types and constants for the frame status LED controller: frame
// identifiers, blink mode slots, indicator codes and the bundles that pass
// between the input stage, the status core and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsl_pkg;

    // field widths
    localparam int unsigned IdW     = 29;
    localparam int unsigned LenW    = 4;
    localparam int unsigned DataW   = 64;
    localparam int unsigned LevelW  = 8;
    localparam int unsigned MsW     = 16;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    // default pwm resolution
    localparam int unsigned PwmBitsDefault = 8;

    // input commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // frame identifiers of interest
    localparam logic [IdW-1:0] ID_MODE    = 29'h05FF4609;
    localparam logic [IdW-1:0] ID_POWER   = 29'h05FF4000;
    localparam logic [IdW-1:0] ID_CURRENT = 29'h05FF4001;

    // blink mode slots
    localparam int unsigned MODE_FAULT   = 0;
    localparam int unsigned MODE_CELEB   = 1;
    localparam int unsigned MODE_STANDBY = 2;
    localparam int unsigned NumModes     = 3;

    // full-power status value in byte 0
    localparam logic [7:0] MODE_FULL_POWER = 8'd3;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_RED_LEVEL      = 3'd0,
        REG_GREEN_LEVEL    = 3'd1,
        REG_COMMON_ANODE   = 3'd2,
        REG_FAULT_BLINK    = 3'd3,
        REG_CELEB_BLINK    = 3'd4,
        REG_CELEB_WINDOW   = 3'd5,
        REG_STANDBY_BLINK  = 3'd6
    } reg_idx_t;

    // register reset values
    localparam logic [LevelW-1:0] RED_LEVEL_RST      = 8'd14;
    localparam logic [LevelW-1:0] GREEN_LEVEL_RST    = 8'd14;
    localparam logic [MsW-1:0]    FAULT_BLINK_RST    = 16'd250;
    localparam logic [MsW-1:0]    CELEB_BLINK_RST    = 16'd200;
    localparam logic [MsW-1:0]    CELEB_WINDOW_RST   = 16'd1000;
    localparam logic [MsW-1:0]    STANDBY_BLINK_RST  = 16'd1000;

    // indicator codes
    typedef enum logic [1:0] {
        IND_STANDBY = 2'd0,
        IND_CELEB   = 2'd1,
        IND_ACTIVE  = 2'd2,
        IND_FAULT   = 2'd3
    } ind_t;

    // configuration bundle
    typedef struct packed {
        logic [LevelW-1:0] red_level;
        logic [LevelW-1:0] green_level;
        logic              common_anode;
        logic [MsW-1:0]    fault_blink_ms;
        logic [MsW-1:0]    celebrate_blink_ms;
        logic [MsW-1:0]    celebrate_window_ms;
        logic [MsW-1:0]    standby_blink_ms;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic             cmd;
        logic             frame_extended;
        logic [IdW-1:0]   frame_id;
        logic [LenW-1:0]  frame_length;
        logic [DataW-1:0] frame_data;
    } item_t;

    // one result before polarity handling
    typedef struct packed {
        logic [LevelW-1:0] led_red;
        logic [LevelW-1:0] led_green;
        logic [LevelW-1:0] led_blue;
        ind_t              indicator;
        logic              full_power;
        logic              fault_active;
    } result_t;

endpackage : bfsl_pkg

`default_nettype wire

// ===== hw/rtl/bfsl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bfsl_cfg_regs
// Configuration register file: seven write-only registers loaded through a
// plain write port; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsl_cfg_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bfsl_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [bfsl_pkg::CfgDataW-1:0]   cfg_data,
    output bfsl_pkg::cfg_t                       cfg
);

    bfsl_pkg::cfg_t cfg_reg;
    bfsl_pkg::cfg_t cfg_next;

    // decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (bfsl_pkg::reg_idx_t'(cfg_index))
                bfsl_pkg::REG_RED_LEVEL:
                    cfg_next.red_level = cfg_data[bfsl_pkg::LevelW-1:0];
                bfsl_pkg::REG_GREEN_LEVEL:
                    cfg_next.green_level = cfg_data[bfsl_pkg::LevelW-1:0];
                bfsl_pkg::REG_COMMON_ANODE:
                    cfg_next.common_anode = cfg_data[0];
                bfsl_pkg::REG_FAULT_BLINK:
                    cfg_next.fault_blink_ms = cfg_data;
                bfsl_pkg::REG_CELEB_BLINK:
                    cfg_next.celebrate_blink_ms = cfg_data;
                bfsl_pkg::REG_CELEB_WINDOW:
                    cfg_next.celebrate_window_ms = cfg_data;
                bfsl_pkg::REG_STANDBY_BLINK:
                    cfg_next.standby_blink_ms = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_level           <= bfsl_pkg::RED_LEVEL_RST;
            cfg_reg.green_level         <= bfsl_pkg::GREEN_LEVEL_RST;
            cfg_reg.common_anode        <= 1'b0;
            cfg_reg.fault_blink_ms      <= bfsl_pkg::FAULT_BLINK_RST;
            cfg_reg.celebrate_blink_ms  <= bfsl_pkg::CELEB_BLINK_RST;
            cfg_reg.celebrate_window_ms <= bfsl_pkg::CELEB_WINDOW_RST;
            cfg_reg.standby_blink_ms    <= bfsl_pkg::STANDBY_BLINK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : bfsl_cfg_regs

`default_nettype wire

// ===== hw/rtl/bfsl_in_stage.sv =====
// ----------------------------------------------------------------------------
// bfsl_in_stage
// Input register: captures one transaction and holds it until the status
// core consumes it, stalling the sender while it is held and cannot be consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsl_in_stage
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bfsl_pkg::item_t               in_item,
    input  wire logic                          down_ready,
    output logic                               item_fire,
    output bfsl_pkg::item_t                    item
);

    logic            valid_reg;
    logic            valid_next;
    bfsl_pkg::item_t item_reg;
    logic            load;

    // consume when the output side can take a result
    assign item_fire = valid_reg && down_ready;
    assign in_stall  = valid_reg && !down_ready;
    assign load      = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_fire)
        begin
            valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item = item_reg;

endmodule : bfsl_in_stage

`default_nettype wire

// ===== hw/rtl/bfsl_status_core.sv =====
// ----------------------------------------------------------------------------
// bfsl_status_core
// Status core: millisecond clock, frame flag decode, activation tracking and
// the priority machine with its three blink timers and the LED levels.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsl_status_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bfsl_pkg::cfg_t      cfg,
    input  wire logic                item_fire,
    input  wire bfsl_pkg::item_t     item,
    output bfsl_pkg::result_t        result
);

    localparam int unsigned TW = bfsl_pkg::TimeW;
    localparam int unsigned LW = bfsl_pkg::LevelW;
    localparam int unsigned NM = bfsl_pkg::NumModes;

    // architectural state
    logic [TW-1:0] time_reg,        time_next;
    logic          full_power_reg,  full_power_next;
    logic          overpower_reg,   overpower_next;
    logic          overcurrent_reg, overcurrent_next;
    logic          prev_active_reg, prev_active_next;
    logic          act_seen_reg,    act_seen_next;
    logic [TW-1:0] act_time_reg,    act_time_next;
    logic [TW-1:0] last_reg  [NM];
    logic [TW-1:0] last_next [NM];
    logic [NM-1:0] phase_reg,       phase_next;
    logic [LW-1:0] red_reg,         red_next;
    logic [LW-1:0] green_reg,       green_next;
    logic [LW-1:0] blue_reg,        blue_next;

    logic          is_frame;
    logic          len_ge4;
    logic          len_ge8;
    logic          fault;
    logic          rise;
    logic          in_window;
    logic [TW-1:0] since_act;
    logic [TW-1:0] interval [NM];
    logic [NM-1:0] due;
    bfsl_pkg::ind_t ind;

    // frame decode and millisecond clock
    assign is_frame = (item.cmd == bfsl_pkg::CMD_FRAME) && item.frame_extended;
    assign len_ge4  = item.frame_length[3] || item.frame_length[2];
    assign len_ge8  = item.frame_length[3];

    always_comb
    begin
        time_next        = time_reg + TW'(item.cmd == bfsl_pkg::CMD_TICK);
        full_power_next  = full_power_reg;
        overpower_next   = overpower_reg;
        overcurrent_next = overcurrent_reg;
        if (is_frame)
        begin
            if (item.frame_id == bfsl_pkg::ID_MODE && len_ge4)
            begin
                full_power_next = (item.frame_data[7:0] == bfsl_pkg::MODE_FULL_POWER);
            end
            else if (item.frame_id == bfsl_pkg::ID_POWER && len_ge8)
            begin
                overpower_next = (item.frame_data[63:56] != 8'd0);
            end
            else if (item.frame_id == bfsl_pkg::ID_CURRENT && len_ge4)
            begin
                overcurrent_next = (item.frame_data[31:24] != 8'd0);
            end
        end
    end

    // activation tracking
    assign fault            = overpower_next || overcurrent_next;
    assign rise             = full_power_next && !prev_active_reg;
    assign prev_active_next = full_power_next;
    assign act_seen_next    = act_seen_reg || rise;
    assign act_time_next    = rise ? time_next : act_time_reg;
    assign since_act        = time_next - act_time_next;
    assign in_window        = act_seen_next
                              && (since_act < TW'(cfg.celebrate_window_ms));

    // blink timers, one compare per mode
    assign interval[bfsl_pkg::MODE_FAULT]   = TW'(cfg.fault_blink_ms);
    assign interval[bfsl_pkg::MODE_CELEB]   = TW'(cfg.celebrate_blink_ms);
    assign interval[bfsl_pkg::MODE_STANDBY] = TW'(cfg.standby_blink_ms);

    always_comb
    begin
        for (int m = 0; m < NM; m++)
        begin
            due[m] = (time_next - last_reg[m]) >= interval[m];
        end
    end

    // priority machine and led levels
    always_comb
    begin
        for (int m = 0; m < NM; m++)
        begin
            last_next[m] = last_reg[m];
        end
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (fault)
        begin
            ind = bfsl_pkg::IND_FAULT;
            if (due[bfsl_pkg::MODE_FAULT])
            begin
                last_next[bfsl_pkg::MODE_FAULT]  = time_next;
                phase_next[bfsl_pkg::MODE_FAULT] = !phase_reg[bfsl_pkg::MODE_FAULT];
                red_next   = phase_reg[bfsl_pkg::MODE_FAULT] ? '0 : cfg.red_level;
                green_next = '0;
                blue_next  = '0;
            end
        end
        else if (in_window)
        begin
            ind = bfsl_pkg::IND_CELEB;
            if (due[bfsl_pkg::MODE_CELEB])
            begin
                last_next[bfsl_pkg::MODE_CELEB]  = time_next;
                phase_next[bfsl_pkg::MODE_CELEB] = !phase_reg[bfsl_pkg::MODE_CELEB];
                red_next   = phase_reg[bfsl_pkg::MODE_CELEB] ? '0 : cfg.red_level;
                green_next = phase_reg[bfsl_pkg::MODE_CELEB] ? '0 : cfg.green_level;
                blue_next  = '0;
            end
        end
        else if (full_power_next)
        begin
            ind        = bfsl_pkg::IND_ACTIVE;
            red_next   = '0;
            green_next = cfg.green_level;
            blue_next  = '0;
        end
        else
        begin
            ind = bfsl_pkg::IND_STANDBY;
            if (due[bfsl_pkg::MODE_STANDBY])
            begin
                last_next[bfsl_pkg::MODE_STANDBY]  = time_next;
                phase_next[bfsl_pkg::MODE_STANDBY] = !phase_reg[bfsl_pkg::MODE_STANDBY];
                red_next   = phase_reg[bfsl_pkg::MODE_STANDBY] ? '0 : cfg.red_level;
                green_next = phase_reg[bfsl_pkg::MODE_STANDBY] ? '0 : cfg.green_level;
                blue_next  = '0;
            end
        end
    end

    // state update on each consumed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg        <= '0;
            full_power_reg  <= 1'b0;
            overpower_reg   <= 1'b0;
            overcurrent_reg <= 1'b0;
            prev_active_reg <= 1'b0;
            act_seen_reg    <= 1'b0;
            act_time_reg    <= '0;
            for (int m = 0; m < NM; m++)
            begin
                last_reg[m] <= '0;
            end
            phase_reg <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else if (item_fire)
        begin
            time_reg        <= time_next;
            full_power_reg  <= full_power_next;
            overpower_reg   <= overpower_next;
            overcurrent_reg <= overcurrent_next;
            prev_active_reg <= prev_active_next;
            act_seen_reg    <= act_seen_next;
            act_time_reg    <= act_time_next;
            for (int m = 0; m < NM; m++)
            begin
                last_reg[m] <= last_next[m];
            end
            phase_reg <= phase_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // result of the current transaction
    assign result.led_red      = red_next;
    assign result.led_green    = green_next;
    assign result.led_blue     = blue_next;
    assign result.indicator    = ind;
    assign result.full_power   = full_power_next;
    assign result.fault_active = fault;

endmodule : bfsl_status_core

`default_nettype wire

// ===== hw/rtl/bfsl_out_stage.sv =====
// ----------------------------------------------------------------------------
// bfsl_out_stage
// Output register: applies the LED polarity to the levels and holds the
// result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsl_out_stage
#(
    parameter int unsigned PWM_BITS = bfsl_pkg::PwmBitsDefault
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bfsl_pkg::cfg_t                cfg,
    input  wire logic                          load,
    input  wire bfsl_pkg::result_t             result,
    output logic                               ready,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bfsl_pkg::result_t                  out_result
);

    localparam int unsigned LW = bfsl_pkg::LevelW;
    // inverted level keeps the low min(PWM_BITS, 8) bits of the complement
    localparam logic [LW-1:0] InvMask = (PWM_BITS >= LW) ? {LW{1'b1}}
                                        : LW'((1 << PWM_BITS) - 1);

    logic              valid_reg;
    logic              valid_next;
    bfsl_pkg::result_t result_reg;
    bfsl_pkg::result_t result_pol;

    assign ready = !valid_reg || !out_stall;

    // polarity
    always_comb
    begin
        result_pol = result;
        if (cfg.common_anode)
        begin
            result_pol.led_red   = ~result.led_red   & InvMask;
            result_pol.led_green = ~result.led_green & InvMask;
            result_pol.led_blue  = ~result.led_blue  & InvMask;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_pol;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule : bfsl_out_stage

`default_nettype wire

// ===== hw/rtl/bms_frame_status_led_controller_core.sv =====
// ----------------------------------------------------------------------------
// bms_frame_status_led_controller_core
// Battery status LED controller: takes millisecond ticks and received frames,
// tracks the power and fault flags and drives an RGB LED pattern per item.
// ----------------------------------------------------------------------------
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+------------------------------
//  input      | in        | in_valid / in_stall  | cmd, frame_* fields
//  output     | out       | out_valid / out_stall| pwm_*, indicator_state, flags
//  config     | in        | cfg_write            | cfg_index, cfg_data
//
//  one transaction per cycle sustained while out_stall stays low; an item
//  is held in the input register, then its result in the result register,
//  which drives the output
//  the status core updates its state in the cycle it consumes an item
//  reset clears the handshake, the status state and the registers to defaults
//  a stall on the output holds the result and backs up into in_stall
//
`default_nettype none

module bms_frame_status_led_controller_core
#(
    parameter int unsigned PWM_BITS = bfsl_pkg::PwmBitsDefault
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [bfsl_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [bfsl_pkg::CfgDataW-1:0]     cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic                              frame_extended,
    input  wire logic [bfsl_pkg::IdW-1:0]          frame_id,
    input  wire logic [bfsl_pkg::LenW-1:0]         frame_length,
    input  wire logic [bfsl_pkg::DataW-1:0]        frame_data,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bfsl_pkg::LevelW-1:0]            pwm_red,
    output logic [bfsl_pkg::LevelW-1:0]            pwm_green,
    output logic [bfsl_pkg::LevelW-1:0]            pwm_blue,
    output logic [1:0]                             indicator_state,
    output logic                                   full_power,
    output logic                                   fault_active
);

    bfsl_pkg::cfg_t    cfg;
    bfsl_pkg::item_t   in_item;
    bfsl_pkg::item_t   item;
    bfsl_pkg::result_t result;
    bfsl_pkg::result_t out_result;
    logic              item_fire;
    logic              down_ready;

    // gather the input fields
    assign in_item.cmd            = cmd;
    assign in_item.frame_extended = frame_extended;
    assign in_item.frame_id       = frame_id;
    assign in_item.frame_length   = frame_length;
    assign in_item.frame_data     = frame_data;

    // configuration registers
    bfsl_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    bfsl_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .down_ready (down_ready),
        .item_fire  (item_fire),
        .item       (item)
    );

    // status and pattern logic
    bfsl_status_core u_status_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_fire (item_fire),
        .item      (item),
        .result    (result)
    );

    // result register
    bfsl_out_stage
    #(
        .PWM_BITS (PWM_BITS)
    )
    u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .load       (item_fire),
        .result     (result),
        .ready      (down_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    // split the result onto its ports
    assign pwm_red         = out_result.led_red;
    assign pwm_green       = out_result.led_green;
    assign pwm_blue        = out_result.led_blue;
    assign indicator_state = out_result.indicator;
    assign full_power      = out_result.full_power;
    assign fault_active    = out_result.fault_active;

endmodule : bms_frame_status_led_controller_core

`default_nettype wire

// ===== tb/tb_bms_frame_status_led_controller_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bms_frame_status_led_controller_core
// Self-checking bench for the battery status LED controller. Ticks and CAN
// frames are sent through the valid/stall input port while a local model of
// the flags, the priority machine and the blink timers predicts every
// result. Results are compared field by field in arrival order, under
// several register settings and random idling on both ports.
// ----------------------------------------------------------------------------

module tb_bms_frame_status_led_controller_core;

    import bfsl_pkg::*;

    localparam int unsigned     QUIET_LIMIT   = 2000;
    localparam int unsigned     SETTLE_CYCLES = 6;
    localparam logic [IdW-1:0]  ID_BUS_LIFE   = 29'h05FF4610;
    localparam logic [CfgIdxW-1:0] REG_SPARE  = 3'd7;

    // expected content of one result transaction
    typedef struct packed {
        logic [LevelW-1:0] red;
        logic [LevelW-1:0] green;
        logic [LevelW-1:0] blue;
        ind_t              ind;
        logic              fp;
        logic              flt;
    } led_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                cfg_write;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    logic                in_valid;
    logic                in_stall;
    logic                cmd;
    logic                frame_extended;
    logic [IdW-1:0]      frame_id;
    logic [LenW-1:0]     frame_length;
    logic [DataW-1:0]    frame_data;

    logic                out_valid;
    logic                out_stall;
    logic [LevelW-1:0]   pwm_red;
    logic [LevelW-1:0]   pwm_green;
    logic [LevelW-1:0]   pwm_blue;
    logic [1:0]          indicator_state;
    logic                full_power;
    logic                fault_active;

    // model state
    cfg_t              led_cfg;
    logic [TimeW-1:0]  ms_clock;
    logic              fp_flag;
    logic              op_flag;
    logic              oc_flag;
    logic              fp_prev;
    logic              act_seen;
    logic [TimeW-1:0]  act_stamp;
    logic [TimeW-1:0]  toggle_stamp [NumModes];
    logic              phase_bit [NumModes];
    logic [LevelW-1:0] lamp_r;
    logic [LevelW-1:0] lamp_g;
    logic [LevelW-1:0] lamp_b;

    led_result_t expected_leds [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned in_gap_pct = 0;
    int unsigned out_gap_pct = 0;
    int unsigned stall_left = 0;

    bms_frame_status_led_controller_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .frame_extended  (frame_extended),
        .frame_id        (frame_id),
        .frame_length    (frame_length),
        .frame_data      (frame_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pwm_red         (pwm_red),
        .pwm_green       (pwm_green),
        .pwm_blue        (pwm_blue),
        .indicator_state (indicator_state),
        .full_power      (full_power),
        .fault_active    (fault_active)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the controller
    // ------------------------------------------------------------------------

    function automatic void clear_model();
        int unsigned k;
        led_cfg.red_level           = RED_LEVEL_RST;
        led_cfg.green_level         = GREEN_LEVEL_RST;
        led_cfg.common_anode        = 1'b0;
        led_cfg.fault_blink_ms      = FAULT_BLINK_RST;
        led_cfg.celebrate_blink_ms  = CELEB_BLINK_RST;
        led_cfg.celebrate_window_ms = CELEB_WINDOW_RST;
        led_cfg.standby_blink_ms    = STANDBY_BLINK_RST;
        ms_clock  = '0;
        fp_flag   = 1'b0;
        op_flag   = 1'b0;
        oc_flag   = 1'b0;
        fp_prev   = 1'b0;
        act_seen  = 1'b0;
        act_stamp = '0;
        for (k = 0; k < NumModes; k++)
        begin
            toggle_stamp[k] = '0;
            phase_bit[k]    = 1'b0;
        end
        lamp_r = '0;
        lamp_g = '0;
        lamp_b = '0;
    endfunction

    // register write as the block sees it, unused bits dropped
    function automatic void mirror_reg(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] data);
        case (idx)
            REG_RED_LEVEL:     led_cfg.red_level           = data[LevelW-1:0];
            REG_GREEN_LEVEL:   led_cfg.green_level         = data[LevelW-1:0];
            REG_COMMON_ANODE:  led_cfg.common_anode        = data[0];
            REG_FAULT_BLINK:   led_cfg.fault_blink_ms      = data[MsW-1:0];
            REG_CELEB_BLINK:   led_cfg.celebrate_blink_ms  = data[MsW-1:0];
            REG_CELEB_WINDOW:  led_cfg.celebrate_window_ms = data[MsW-1:0];
            REG_STANDBY_BLINK: led_cfg.standby_blink_ms    = data[MsW-1:0];
            default: ;
        endcase
    endfunction

    // toggle a blink slot once its interval has passed, colour on the on phase
    function automatic void blink_step(input int unsigned slot, input logic [TimeW-1:0] now,
                                       input logic [MsW-1:0] period,
                                       input logic [LevelW-1:0] r, input logic [LevelW-1:0] g);
        logic [TimeW-1:0] since;
        since = now - toggle_stamp[slot];
        if (since >= {16'd0, period})
        begin
            toggle_stamp[slot] = now;
            phase_bit[slot]    = ~phase_bit[slot];
            lamp_r = phase_bit[slot] ? r : '0;
            lamp_g = phase_bit[slot] ? g : '0;
            lamp_b = '0;
        end
    endfunction

    // common-anode inversion at the pwm resolution
    function automatic logic [LevelW-1:0] drive_level(input logic [LevelW-1:0] v);
        int unsigned full_scale;
        full_scale = (1 << PwmBitsDefault) - 1;
        if (led_cfg.common_anode)
            return LevelW'((full_scale - v) & full_scale);
        return v;
    endfunction

    // apply one item and return the LED result it causes
    function automatic led_result_t advance_indicator(input item_t it);
        logic [TimeW-1:0] now;
        logic [TimeW-1:0] since_act;
        logic             flt;
        led_result_t      res;

        // flag updates from known extended frames
        if (it.cmd == CMD_TICK)
            ms_clock = ms_clock + 32'd1;
        else if (it.frame_extended)
        begin
            if (it.frame_id == ID_MODE && it.frame_length >= 4'd4)
                fp_flag = (it.frame_data[7:0] == MODE_FULL_POWER);
            else if (it.frame_id == ID_POWER && it.frame_length >= 4'd8)
                op_flag = (it.frame_data[63:56] != 8'd0);
            else if (it.frame_id == ID_CURRENT && it.frame_length >= 4'd4)
                oc_flag = (it.frame_data[31:24] != 8'd0);
        end

        now = ms_clock;
        flt = op_flag | oc_flag;

        // activation on a rising edge of full power
        if (fp_flag && !fp_prev)
        begin
            act_seen  = 1'b1;
            fp_prev   = 1'b1;
            act_stamp = now;
        end
        else if (!fp_flag && fp_prev)
            fp_prev = 1'b0;

        // priority: fault, activation blink, active, standby
        since_act = now - act_stamp;
        if (flt)
        begin
            blink_step(MODE_FAULT, now, led_cfg.fault_blink_ms, led_cfg.red_level, '0);
            res.ind = IND_FAULT;
        end
        else if (act_seen && since_act < {16'd0, led_cfg.celebrate_window_ms})
        begin
            blink_step(MODE_CELEB, now, led_cfg.celebrate_blink_ms,
                       led_cfg.red_level, led_cfg.green_level);
            res.ind = IND_CELEB;
        end
        else if (fp_flag)
        begin
            lamp_r = '0;
            lamp_g = led_cfg.green_level;
            lamp_b = '0;
            res.ind = IND_ACTIVE;
        end
        else
        begin
            blink_step(MODE_STANDBY, now, led_cfg.standby_blink_ms,
                       led_cfg.red_level, led_cfg.green_level);
            res.ind = IND_STANDBY;
        end

        res.red   = drive_level(lamp_r);
        res.green = drive_level(lamp_g);
        res.blue  = drive_level(lamp_b);
        res.fp    = fp_flag;
        res.flt   = flt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------

    function automatic item_t frame_item(input logic ext, input logic [IdW-1:0] id,
                                         input logic [LenW-1:0] len,
                                         input logic [DataW-1:0] data);
        item_t it;
        it.cmd            = CMD_FRAME;
        it.frame_extended = ext;
        it.frame_id       = id;
        it.frame_length   = len;
        it.frame_data     = data;
        return it;
    endfunction

    // tick with junk in the ignored frame fields
    function automatic item_t tick_item();
        item_t it;
        it = frame_item($urandom_range(0, 1), IdW'($urandom), LenW'($urandom),
                        {$urandom, $urandom});
        it.cmd = CMD_TICK;
        return it;
    endfunction

    // mostly ticks and well-formed status frames, some noise
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        int unsigned sub;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 3);
        it = frame_item(1'b1, ID_MODE, LenW'($urandom_range(4, 15)), {$urandom, $urandom});
        if (pick < 50)
            it = tick_item();
        else if (pick < 66)
        begin
            if ($urandom_range(0, 1))
                it.frame_data[7:0] = MODE_FULL_POWER;
        end
        else if (pick < 76)
        begin
            it.frame_id     = ID_POWER;
            it.frame_length = LenW'($urandom_range(8, 15));
            if ($urandom_range(0, 2) != 0)
                it.frame_data[63:56] = 8'd0;
        end
        else if (pick < 86)
        begin
            it.frame_id = ID_CURRENT;
            if ($urandom_range(0, 2) != 0)
                it.frame_data[31:24] = 8'd0;
        end
        else
        begin
            case (sub)
                0: it.frame_extended = 1'b0;
                1: it.frame_id = ID_BUS_LIFE;
                2: it.frame_id = IdW'($urandom);
                default:
                begin
                    it.frame_id     = ($urandom_range(0, 1)) ? ID_POWER : ID_CURRENT;
                    it.frame_length = LenW'($urandom_range(0, 7));
                    if (it.frame_id == ID_CURRENT)
                        it.frame_length = LenW'($urandom_range(0, 3));
                end
            endcase
            if (it.frame_data[7:0] != MODE_FULL_POWER && $urandom_range(0, 1))
                it.frame_data[7:0] = MODE_FULL_POWER;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // send one input transaction and record what it should produce
    task automatic send_item(input item_t it);
        if ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= it.cmd;
        frame_extended <= it.frame_extended;
        frame_id       <= it.frame_id;
        frame_length   <= it.frame_length;
        frame_data     <= it.frame_data;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        expected_leds.push_back(advance_indicator(it));
    endtask

    // let every outstanding result come out
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write every register, junk in the unused upper bits, then the spare index
    task automatic load_setting(input cfg_t s);
        logic [CfgDataW-1:0] word [8];
        int unsigned         k;
        word[REG_RED_LEVEL]     = {8'($urandom), s.red_level};
        word[REG_GREEN_LEVEL]   = {8'($urandom), s.green_level};
        word[REG_COMMON_ANODE]  = {15'($urandom), s.common_anode};
        word[REG_FAULT_BLINK]   = s.fault_blink_ms;
        word[REG_CELEB_BLINK]   = s.celebrate_blink_ms;
        word[REG_CELEB_WINDOW]  = s.celebrate_window_ms;
        word[REG_STANDBY_BLINK] = s.standby_blink_ms;
        word[REG_SPARE]         = CfgDataW'($urandom);
        for (k = 0; k < 8; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CfgIdxW'(k);
            cfg_data  <= word[k];
            @(posedge clk);
            mirror_reg(CfgIdxW'(k), word[k]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input cfg_t s, input int unsigned count);
        int unsigned n;
        drain_pipeline();
        load_setting(s);
        for (n = 0; n < count; n++)
            send_item(random_item());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings, frame filtering and flag set/clear
    task automatic test_directed_cases();
        item_t it;
        in_gap_pct  = 20;
        out_gap_pct = 20;
        send_item(frame_item(1'b0, '0, '0, '0));
        it = frame_item(1'b1, '1, '1, '1);
        it.cmd = CMD_TICK;
        send_item(it);
        send_item(frame_item(1'b0, ID_MODE, 4'd8, 64'hFFFF_FFFF_FFFF_FF03));
        send_item(frame_item(1'b1, ID_BUS_LIFE, 4'd8, '1));
        send_item(frame_item(1'b1, 29'h1ABC_DEF0, 4'd8, 64'h0000_0000_0000_0003));
        send_item(frame_item(1'b1, ID_MODE, 4'd3, 64'h0000_0000_0000_0003));
        send_item(frame_item(1'b1, ID_MODE, 4'd4, 64'h0000_0000_0000_0003));
        send_item(tick_item());
        send_item(frame_item(1'b1, ID_MODE, 4'd15, 64'h0000_0000_0000_0002));
        send_item(frame_item(1'b1, ID_MODE, 4'd8, 64'h5555_5555_5555_5503));
        send_item(tick_item());
        send_item(frame_item(1'b1, ID_POWER, 4'd7, 64'hFF00_0000_0000_0000));
        send_item(frame_item(1'b1, ID_POWER, 4'd8, 64'h8000_0000_0000_0000));
        send_item(tick_item());
        send_item(frame_item(1'b1, ID_POWER, 4'd8, 64'h00FF_FFFF_FFFF_FFFF));
        send_item(frame_item(1'b1, ID_CURRENT, 4'd3, 64'h0000_0000_0100_0000));
        send_item(frame_item(1'b1, ID_CURRENT, 4'd4, 64'h0000_0000_0100_0000));
        send_item(frame_item(1'b1, ID_CURRENT, 4'd15, 64'hFFFF_FFFF_00FF_FFFF));
        send_item(frame_item(1'b1, ID_MODE, 4'd0, 64'h0000_0000_0000_0003));
        send_item(frame_item(1'b1, ID_MODE, 4'd9, 64'h0000_0000_0000_0000));
        send_item(tick_item());
    endtask

    // full-scale red, no green, inverted outputs, one-millisecond intervals and window
    task automatic test_level_extremes();
        cfg_t s;
        s = '{red_level: 8'hFF, green_level: 8'h00, common_anode: 1'b1,
              fault_blink_ms: 16'd1, celebrate_blink_ms: 16'd1,
              celebrate_window_ms: 16'd1, standby_blink_ms: 16'd1};
        in_gap_pct  = 30;
        out_gap_pct = 10;
        run_phase(s, 150);
    endtask

    // zero intervals toggle on every item, zero window hides activation
    task automatic test_zero_intervals();
        cfg_t s;
        s = '{red_level: 8'h00, green_level: 8'hFF, common_anode: 1'b0,
              fault_blink_ms: 16'd0, celebrate_blink_ms: 16'd0,
              celebrate_window_ms: 16'd0, standby_blink_ms: 16'd0};
        in_gap_pct  = 10;
        out_gap_pct = 30;
        run_phase(s, 150);
    endtask

    // largest intervals and window
    task automatic test_long_intervals();
        cfg_t s;
        s = '{red_level: 8'($urandom), green_level: 8'($urandom), common_anode: 1'b1,
              fault_blink_ms: 16'hFFFF, celebrate_blink_ms: 16'hFFFF,
              celebrate_window_ms: 16'hFFFF, standby_blink_ms: 16'hFFFF};
        in_gap_pct  = 0;
        out_gap_pct = 25;
        run_phase(s, 120);
    endtask

    // short random timing so blinks and windows come and go
    task automatic test_random_settings();
        cfg_t        s;
        int unsigned p;
        for (p = 0; p < 3; p++)
        begin
            s.red_level           = 8'($urandom);
            s.green_level         = 8'($urandom);
            s.common_anode        = 1'($urandom);
            s.fault_blink_ms      = 16'($urandom_range(1, 12));
            s.celebrate_blink_ms  = 16'($urandom_range(1, 12));
            s.celebrate_window_ms = 16'($urandom_range(5, 60));
            s.standby_blink_ms    = 16'($urandom_range(0, 12));
            in_gap_pct            = $urandom_range(0, 2) * 15;
            out_gap_pct           = $urandom_range(0, 2) * 15;
            run_phase(s, 150);
        end
    endtask

    // back-to-back traffic with no idling at the end of the run
    task automatic test_steady_flow();
        cfg_t s;
        s = '{red_level: 8'($urandom), green_level: 8'($urandom), common_anode: 1'b0,
              fault_blink_ms: 16'd3, celebrate_blink_ms: 16'd2,
              celebrate_window_ms: 16'd20, standby_blink_ms: 16'd4};
        in_gap_pct  = 0;
        out_gap_pct = 0;
        run_phase(s, 100);
    endtask

    // ------------------------------------------------------------------------
    // random output stall bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < out_gap_pct)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // result checking against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        led_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_leds.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: result transaction with nothing expected", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = expected_leds.pop_front();
                if (pwm_red !== want.red || pwm_green !== want.green ||
                    pwm_blue !== want.blue || indicator_state !== want.ind ||
                    full_power !== want.fp || fault_active !== want.flt)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp r=%h g=%h b=%h ind=%0d fp=%b flt=%b, got r=%h g=%h b=%h ind=%0d fp=%b flt=%b",
                                 $realtime, want.red, want.green, want.blue, want.ind,
                                 want.fp, want.flt, pwm_red, pwm_green, pwm_blue,
                                 indicator_state, full_power, fault_active);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog on cycles without any transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_bms_frame_status_led_controller_core: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        cmd            <= CMD_TICK;
        frame_extended <= 1'b0;
        frame_id       <= '0;
        frame_length   <= '0;
        frame_data     <= '0;
        out_stall      <= 1'b0;
        clear_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_level_extremes();
        test_zero_intervals();
        test_long_intervals();
        test_random_settings();
        test_steady_flow();

        drain_pipeline();
        if (mismatch_count == 0 && expected_leds.size() == 0)
            $display("tb_bms_frame_status_led_controller_core: done, clean");
        else
            $display("tb_bms_frame_status_led_controller_core: done, errors");
        $finish;
    end

endmodule
